### hw/rtl/mec_pkg.sv
// Shared types, constants and helpers for the escape-time counter.
// Used by mec_front, mec_queue, mec_back and the top level; depends on nothing.
package mec_pkg;

  localparam int FracBits   = 28;
  localparam int MaxSide    = 4096;
  localparam int IdxW       = 12;
  localparam int CoordW     = 32;
  localparam int CountW     = 16;
  localparam int ProdW      = 2 * CoordW;
  localparam int IdxProdW   = IdxW + 1 + CoordW;
  localparam int WideW      = 48;
  localparam int CfgIdxW    = 3;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [WideW-1:0]  wide_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_ITERS  = 3'd0,
    CFG_LEFT_EDGE  = 3'd1,
    CFG_LOWER_EDGE = 3'd2,
    CFG_X_STEP     = 3'd3,
    CFG_Y_STEP     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD
  } back_state_e;

  typedef struct packed {
    logic [CountW-1:0] max_iters;
    coord_t            left_edge;
    coord_t            lower_edge;
    coord_t            x_step;
    coord_t            y_step;
  } cfg_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [CountW-1:0] MaxItersReset = CountW'(256);
  localparam coord_t EdgeReset   = -(CoordW'(2) << FracBits);
  localparam coord_t StepReset   = CoordW'(1) << (FracBits - 10);
  localparam wide_t  EscapeLimit = WideW'(4) << FracBits;

  function automatic coord_t sat_coord(input wide_t v);
    logic [WideW-CoordW:0] top;
    top = v[WideW-1:CoordW-1];
    if (top == '0 || top == '1) begin
      return v[CoordW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

  function automatic logic [IdxW-1:0] clamp_idx(input logic [IdxW-1:0] v);
    if (int'(v) >= MaxSide) begin
      return IdxW'(MaxSide - 1);
    end
    return v;
  endfunction

endpackage

### hw/rtl/mec_front.sv
// Front end: takes a pixel, clamps the indices and maps it to the point c.
// Depends on mec_pkg; feeds mec_queue.
module mec_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [mec_pkg::IdxW-1:0] column_i,
  input  logic [mec_pkg::IdxW-1:0] row_i,
  input  mec_pkg::cfg_t          cfg_i,
  input  mec_pkg::q_status_t     q_status_i,
  output logic                   busy_o,
  output logic                   push_o,
  output mec_pkg::point_t        point_o
);
  import mec_pkg::*;

  logic                       s1_v_q, s2_v_q;
  logic [IdxW-1:0]            col_q, row_q;
  logic signed [IdxProdW-1:0] px_q, py_q;
  logic signed [IdxProdW-1:0] px_d, py_d;

  // one item in flight at a time; queue space is checked at accept
  assign busy_o = s1_v_q | s2_v_q | q_status_i.full;

  assign px_d = $signed({1'b0, col_q}) * $signed(cfg_i.x_step);
  assign py_d = $signed({1'b0, row_q}) * $signed(cfg_i.y_step);

  assign push_o     = s2_v_q;
  assign point_o.cx = sat_coord(wide_t'($signed(cfg_i.left_edge)) + wide_t'(px_q));
  assign point_o.cy = sat_coord(wide_t'($signed(cfg_i.lower_edge)) + wide_t'(py_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      col_q <= clamp_idx(column_i);
      row_q <= clamp_idx(row_i);
    end
    if (s1_v_q) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

endmodule

### hw/rtl/mec_queue.sv
// Short point queue between the front end and the iterator.
// Depends on mec_pkg.
module mec_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mec_pkg::point_t    wdata_i,
  input  logic               pop_i,
  output mec_pkg::point_t    rdata_o,
  output mec_pkg::q_status_t status_o
);
  import mec_pkg::*;

  point_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  assign status_o.full  = (cnt_q == (QPtrW+1)'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hw/rtl/mec_back.sv
// Back end: runs the z = z*z + c orbit, one step per pass through its multiply and update states.
// Depends on mec_pkg; pulls points from mec_queue.
module mec_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mec_pkg::CountW-1:0] max_iters_i,
  input  mec_pkg::q_status_t         q_status_i,
  input  mec_pkg::point_t            point_i,
  output logic                       pop_o,
  output logic                       result_valid_o,
  output logic [mec_pkg::CountW-1:0] iteration_count_o
);
  import mec_pkg::*;

  back_state_e             state_q, state_d;
  coord_t                  x_q, y_q, cx_q, cy_q;
  logic [CountW-1:0]       count_q;
  logic signed [ProdW-1:0] pxx_q, pyy_q, pxy_q;
  logic                    res_valid_q;
  logic [CountW-1:0]       res_count_q;

  wide_t  xx, yy, xy2, len2;
  coord_t nx, ny;
  logic   finish;
  logic   load, mul, step, emit;

  // products are of the current z: they give both |z|^2 and the next z
  always_comb begin
    xx     = wide_t'(pxx_q >>> FracBits);
    yy     = wide_t'(pyy_q >>> FracBits);
    xy2    = wide_t'(pxy_q >>> (FracBits - 1));
    len2   = xx + yy;
    finish = (len2 >= EscapeLimit) || (count_q >= max_iters_i);
    nx     = sat_coord(xx - yy + wide_t'(cx_q));
    ny     = sat_coord(xy2 + wide_t'(cy_q));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!q_status_i.empty) state_d = BK_MUL;
      BK_MUL:  state_d = BK_UPD;
      BK_UPD:  state_d = finish ? BK_IDLE : BK_MUL;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    mul  = 1'b0;
    step = 1'b0;
    emit = 1'b0;
    unique case (state_q)
      BK_IDLE: load = !q_status_i.empty;
      BK_MUL:  mul  = 1'b1;
      BK_UPD: begin
        step = !finish;
        emit = finish;
      end
      default: ;
    endcase
  end

  assign pop_o             = load;
  assign result_valid_o    = res_valid_q;
  assign iteration_count_o = res_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cx_q    <= point_i.cx;
      cy_q    <= point_i.cy;
      x_q     <= '0;
      y_q     <= '0;
      count_q <= '0;
    end
    if (mul) begin
      pxx_q <= x_q * x_q;
      pyy_q <= y_q * y_q;
      pxy_q <= x_q * y_q;
    end
    if (step) begin
      x_q     <= nx;
      y_q     <= ny;
      count_q <= count_q + CountW'(1);
    end
    if (emit) begin
      res_count_q <= count_q;
    end
  end

endmodule

### hw/rtl/mandelbrot_escape_counter_core.sv
// Top level: configuration registers, front end, point queue and iterator.
// Depends on mec_pkg, mec_front, mec_queue and mec_back.
//
// Usage:
//   Pixel channel: drive column_i/row_i with start high; the pixel is taken
//   at a rising edge where start is high and busy is low. Indices at or
//   above the image side are clamped to the last column/row.
//   Result channel: result_valid_o is high for one cycle with
//   iteration_count_o; there is no back-pressure, so the receiver must take
//   it in that cycle.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high, unknown indices are dropped. Write only when idle.
// Flow:
//   The iterator runs each orbit step through its multiply/update loop;
//   the result is registered after the final update. The front end maps
//   the next pixels while the iterator runs, up to two waiting in the queue.
// Reset: the configuration registers take their defaults, queue and iterator empty.
module mandelbrot_escape_counter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [mec_pkg::IdxW-1:0]    column_i,
  input  logic [mec_pkg::IdxW-1:0]    row_i,
  output logic                        result_valid_o,
  output logic [mec_pkg::CountW-1:0]  iteration_count_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mec_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mec_pkg::CoordW-1:0]  cfg_data_i
);
  import mec_pkg::*;

  cfg_t      cfg_q;
  logic      accept, push, pop;
  point_t    push_point, pop_point;
  q_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iters  <= MaxItersReset;
      cfg_q.left_edge  <= EdgeReset;
      cfg_q.lower_edge <= EdgeReset;
      cfg_q.x_step     <= StepReset;
      cfg_q.y_step     <= StepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_ITERS:  cfg_q.max_iters  <= cfg_data_i[CountW-1:0];
        CFG_LEFT_EDGE:  cfg_q.left_edge  <= cfg_data_i;
        CFG_LOWER_EDGE: cfg_q.lower_edge <= cfg_data_i;
        CFG_X_STEP:     cfg_q.x_step     <= cfg_data_i;
        CFG_Y_STEP:     cfg_q.y_step     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .column_i   (column_i),
    .row_i      (row_i),
    .cfg_i      (cfg_q),
    .q_status_i (q_status),
    .busy_o     (busy),
    .push_o     (push),
    .point_o    (push_point)
  );

  mec_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_point),
    .pop_i    (pop),
    .rdata_o  (pop_point),
    .status_o (q_status)
  );

  mec_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_iters_i       (cfg_q.max_iters),
    .q_status_i        (q_status),
    .point_i           (pop_point),
    .pop_o             (pop),
    .result_valid_o    (result_valid_o),
    .iteration_count_o (iteration_count_o)
  );

endmodule

### hw/rtl/mec_checker.sv
// Port-level checks for the escape-time counter, bound to the top level.
// Depends on mandelbrot_escape_counter_core's ports only.
module mec_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  logic [2:0] pending_q;
  logic       took, gave;

  assign took = start & ~busy;
  assign gave = result_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (took && !gave) begin
      pending_q <= pending_q + 3'd1;
    end else if (gave && !took) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_no_result_without_pixel: assert property (
    @(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> pending_q != 3'd0
  ) else $error("result without a pending pixel");

  a_busy_after_transfer: assert property (
    @(posedge clk_i) disable iff (!rst_ni) took |=> busy
  ) else $error("busy low right after a pixel transfer");

  a_result_single_cycle: assert property (
    @(posedge clk_i) disable iff (!rst_ni) result_valid_o |=> !result_valid_o
  ) else $error("results on consecutive cycles");

  a_pending_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pending_q <= 3'd5
  ) else $error("too many pixels in flight");

endmodule

bind mandelbrot_escape_counter_core mec_checker u_mec_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);
